### hw/rtl/lodsel_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lodsel_pkg
// Shared widths, register indexes and types of the LOD selector.
// ---------------------------------------------------------------------------
package lodsel_pkg;

   localparam int MAX_OBJECTS = 1024;
   localparam int SLOT_W      = $clog2(MAX_OBJECTS);

   localparam int ID_W     = 10;
   localparam int COORD_W  = 32;
   localparam int DIST_W   = 31;
   localparam int LEVEL_W  = 2;
   localparam int AVAIL_W  = 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEAR     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAR      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARGIN   = 3'd5;

   localparam logic [LEVEL_W-1:0] LEVEL_NEAR = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_FAR  = 2'd2;

   // classification queue between front and back
   localparam int CQ_DEPTH   = 8;
   localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
   localparam int CQ_COUNT_W = $clog2(CQ_DEPTH + 1);

   // front pipeline depth (items in flight before the queue)
   localparam int FE_STAGES   = 4;
   localparam int FE_COUNT_W  = $clog2(FE_STAGES + 1);

   // result queue inside the back end
   localparam int RQ_DEPTH   = 2;
   localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
   localparam int RQ_COUNT_W = $clog2(RQ_DEPTH + 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] camera_x;
      logic signed [COORD_W-1:0] camera_y;
      logic signed [COORD_W-1:0] camera_z;
      logic [DIST_W-1:0]         near_switch_distance;
      logic [DIST_W-1:0]         far_switch_distance;
      logic [DIST_W-1:0]         hysteresis_margin;
   } cfg_type;

   typedef struct packed {
      logic beyond_near_up;
      logic beyond_far_up;
      logic within_near_dn;
      logic within_far_dn;
   } cmp_type;

   typedef struct packed {
      logic [ID_W-1:0]    object_id;
      logic [AVAIL_W-1:0] levels_available;
      logic               restart;
      cmp_type            cmp;
   } job_type;

   typedef struct packed {
      logic [ID_W-1:0]    result_id;
      logic [LEVEL_W-1:0] detail_level;
   } rsp_type;

endpackage
`default_nettype wire

### hw/rtl/lodsel_csr.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lodsel_csr
// Configuration registers: camera position, switch distances and margin.
// ---------------------------------------------------------------------------
module lodsel_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               write_enable,
   input  wire logic [lodsel_pkg::CSR_INDEX_W-1:0] index,
   input  wire logic [lodsel_pkg::CSR_DATA_W-1:0]  wdata,
   output lodsel_pkg::cfg_type                     cfg
);
   import lodsel_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         case (index)
            CSR_CAMERA_X: cfg_in.camera_x             = wdata;
            CSR_CAMERA_Y: cfg_in.camera_y             = wdata;
            CSR_CAMERA_Z: cfg_in.camera_z             = wdata;
            CSR_NEAR:     cfg_in.near_switch_distance = wdata[DIST_W-1:0];
            CSR_FAR:      cfg_in.far_switch_distance  = wdata[DIST_W-1:0];
            CSR_MARGIN:   cfg_in.hysteresis_margin    = wdata[DIST_W-1:0];
            default:      cfg_in = cfg_ff;   // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### hw/rtl/lodsel_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lodsel_front
// Distance pipeline: offsets, magnitudes, squares, sum, threshold compares.
// ---------------------------------------------------------------------------
module lodsel_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic [lodsel_pkg::ID_W-1:0]       object_id,
   input  wire logic [lodsel_pkg::COORD_W-1:0]    pos_x,
   input  wire logic [lodsel_pkg::COORD_W-1:0]    pos_y,
   input  wire logic [lodsel_pkg::COORD_W-1:0]    pos_z,
   input  wire logic [lodsel_pkg::AVAIL_W-1:0]    levels_available,
   input  wire logic                              restart,
   input  wire lodsel_pkg::cfg_type               cfg,
   output logic [lodsel_pkg::FE_COUNT_W-1:0]      in_flight,
   output logic                                   push,
   output lodsel_pkg::job_type                    push_data
);
   import lodsel_pkg::*;

   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W   = 2 * COORD_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int THR_W  = DIST_W + 1;

   typedef struct packed {
      logic [ID_W-1:0]    object_id;
      logic [AVAIL_W-1:0] levels_available;
      logic               restart;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic [DIFF_W-1:0] dx;
      logic [DIFF_W-1:0] dy;
      logic [DIFF_W-1:0] dz;
      logic [THR_W-1:0]  near_up;
      logic [THR_W-1:0]  far_up;
      logic [THR_W-1:0]  near_dn;
      logic [THR_W-1:0]  far_dn;
   } s1_type;

   typedef struct packed {
      tag_type            tag;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [COORD_W-1:0] az;
      logic [THR_W-1:0]   near_up;
      logic [THR_W-1:0]   far_up;
      logic [DIST_W-1:0]  near_dn;
      logic [DIST_W-1:0]  far_dn;
      logic               near_dn_pos;
      logic               far_dn_pos;
   } s2_type;

   typedef struct packed {
      tag_type         tag;
      logic [SQ_W-1:0] sx;
      logic [SQ_W-1:0] sy;
      logic [SQ_W-1:0] sz;
      logic [SQ_W-1:0] t_near_up;
      logic [SQ_W-1:0] t_far_up;
      logic [SQ_W-1:0] t_near_dn;
      logic [SQ_W-1:0] t_far_dn;
      logic            near_dn_pos;
      logic            far_dn_pos;
   } s3_type;

   typedef struct packed {
      tag_type          tag;
      logic [SUM_W-1:0] d2;
      logic [SQ_W-1:0]  t_near_up;
      logic [SQ_W-1:0]  t_far_up;
      logic [SQ_W-1:0]  t_near_dn;
      logic [SQ_W-1:0]  t_far_dn;
      logic             near_dn_pos;
      logic             far_dn_pos;
   } s4_type;

   logic [FE_STAGES-1:0] vld_ff, vld_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;

   logic [DIFF_W-1:0] ndx, ndy, ndz;

   // stage 1: signed offsets and widened thresholds
   always_comb begin
      s1_in.tag.object_id        = object_id;
      s1_in.tag.levels_available = levels_available;
      s1_in.tag.restart          = restart;
      s1_in.dx = {pos_x[COORD_W-1], pos_x} - {cfg.camera_x[COORD_W-1], cfg.camera_x};
      s1_in.dy = {pos_y[COORD_W-1], pos_y} - {cfg.camera_y[COORD_W-1], cfg.camera_y};
      s1_in.dz = {pos_z[COORD_W-1], pos_z} - {cfg.camera_z[COORD_W-1], cfg.camera_z};
      s1_in.near_up = {1'b0, cfg.near_switch_distance} + {1'b0, cfg.hysteresis_margin};
      s1_in.far_up  = {1'b0, cfg.far_switch_distance}  + {1'b0, cfg.hysteresis_margin};
      s1_in.near_dn = {1'b0, cfg.near_switch_distance} - {1'b0, cfg.hysteresis_margin};
      s1_in.far_dn  = {1'b0, cfg.far_switch_distance}  - {1'b0, cfg.hysteresis_margin};
   end

   // stage 2: magnitudes; offsets never reach 2^32 so 32 bits hold them
   assign ndx = ~s1_ff.dx + DIFF_W'(1);
   assign ndy = ~s1_ff.dy + DIFF_W'(1);
   assign ndz = ~s1_ff.dz + DIFF_W'(1);

   always_comb begin
      s2_in.tag     = s1_ff.tag;
      s2_in.ax      = s1_ff.dx[DIFF_W-1] ? ndx[COORD_W-1:0] : s1_ff.dx[COORD_W-1:0];
      s2_in.ay      = s1_ff.dy[DIFF_W-1] ? ndy[COORD_W-1:0] : s1_ff.dy[COORD_W-1:0];
      s2_in.az      = s1_ff.dz[DIFF_W-1] ? ndz[COORD_W-1:0] : s1_ff.dz[COORD_W-1:0];
      s2_in.near_up = s1_ff.near_up;
      s2_in.far_up  = s1_ff.far_up;
      s2_in.near_dn = s1_ff.near_dn[DIST_W-1:0];
      s2_in.far_dn  = s1_ff.far_dn[DIST_W-1:0];
      // a lower threshold of zero or below never matches
      s2_in.near_dn_pos = !s1_ff.near_dn[THR_W-1] && (s1_ff.near_dn != '0);
      s2_in.far_dn_pos  = !s1_ff.far_dn[THR_W-1]  && (s1_ff.far_dn  != '0);
   end

   // stage 3: squares, one multiplier per lane
   always_comb begin
      s3_in.tag         = s2_ff.tag;
      s3_in.sx          = SQ_W'(s2_ff.ax) * SQ_W'(s2_ff.ax);
      s3_in.sy          = SQ_W'(s2_ff.ay) * SQ_W'(s2_ff.ay);
      s3_in.sz          = SQ_W'(s2_ff.az) * SQ_W'(s2_ff.az);
      s3_in.t_near_up   = SQ_W'(s2_ff.near_up) * SQ_W'(s2_ff.near_up);
      s3_in.t_far_up    = SQ_W'(s2_ff.far_up) * SQ_W'(s2_ff.far_up);
      s3_in.t_near_dn   = SQ_W'(s2_ff.near_dn) * SQ_W'(s2_ff.near_dn);
      s3_in.t_far_dn    = SQ_W'(s2_ff.far_dn) * SQ_W'(s2_ff.far_dn);
      s3_in.near_dn_pos = s2_ff.near_dn_pos;
      s3_in.far_dn_pos  = s2_ff.far_dn_pos;
   end

   // stage 4: squared distance
   always_comb begin
      s4_in.tag         = s3_ff.tag;
      s4_in.d2          = SUM_W'(s3_ff.sx) + SUM_W'(s3_ff.sy) + SUM_W'(s3_ff.sz);
      s4_in.t_near_up   = s3_ff.t_near_up;
      s4_in.t_far_up    = s3_ff.t_far_up;
      s4_in.t_near_dn   = s3_ff.t_near_dn;
      s4_in.t_far_dn    = s3_ff.t_far_dn;
      s4_in.near_dn_pos = s3_ff.near_dn_pos;
      s4_in.far_dn_pos  = s3_ff.far_dn_pos;
   end

   assign vld_in = {vld_ff[FE_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
   end

   // classify against the squared thresholds
   always_comb begin
      push_data.object_id          = s4_ff.tag.object_id;
      push_data.levels_available   = s4_ff.tag.levels_available;
      push_data.restart            = s4_ff.tag.restart;
      push_data.cmp.beyond_near_up = s4_ff.d2 > SUM_W'(s4_ff.t_near_up);
      push_data.cmp.beyond_far_up  = s4_ff.d2 > SUM_W'(s4_ff.t_far_up);
      push_data.cmp.within_near_dn = s4_ff.near_dn_pos && (s4_ff.d2 < SUM_W'(s4_ff.t_near_dn));
      push_data.cmp.within_far_dn  = s4_ff.far_dn_pos && (s4_ff.d2 < SUM_W'(s4_ff.t_far_dn));
   end

   assign push      = vld_ff[FE_STAGES-1];
   assign in_flight = FE_COUNT_W'($countones(vld_ff));

endmodule
`default_nettype wire

### hw/rtl/lodsel_cq.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lodsel_cq
// Queue of classified objects between the distance front end and the back.
// ---------------------------------------------------------------------------
module lodsel_cq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire lodsel_pkg::job_type               push_data,
   input  wire logic                              pop,
   output lodsel_pkg::job_type                    pop_data,
   output logic                                   empty,
   output logic [lodsel_pkg::CQ_COUNT_W-1:0]      count
);
   import lodsel_pkg::*;

   job_type               slot_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + CQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CQ_COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CQ_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule
`default_nettype wire

### hw/rtl/lodsel_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lodsel_back
// Level table, hysteresis decision, clipping and the result queue.
// ---------------------------------------------------------------------------
module lodsel_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            job_empty,
   input  wire lodsel_pkg::job_type             job_data,
   output logic                                 job_pop,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_empty,
   output logic [lodsel_pkg::ID_W-1:0]          rsp_result_id,
   output logic [lodsel_pkg::LEVEL_W-1:0]       rsp_detail_level,
   output logic                                 clear_busy
);
   import lodsel_pkg::*;

   localparam logic BK_IDLE   = 1'b0;
   localparam logic BK_LOOKUP = 1'b1;

   logic                  state_ff, state_in;
   job_type               job_ff, job_in;
   logic [LEVEL_W-1:0]    lvl_mem_ff [MAX_OBJECTS];
   logic [LEVEL_W-1:0]    rd_lvl_ff;
   logic [SLOT_W-1:0]     clr_ff, clr_in;
   logic                  clr_busy_ff, clr_busy_in;

   rsp_type               rq_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   rq_wr_ff, rq_wr_in;
   logic [RQ_PTR_W-1:0]   rq_rd_ff, rq_rd_in;
   logic [RQ_COUNT_W-1:0] rq_count_ff, rq_count_in;

   logic                  start;
   logic                  finish;
   logic                  rq_pop;
   logic [LEVEL_W-1:0]    prev;
   logic [LEVEL_W-1:0]    level;
   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   logic [LEVEL_W-1:0]    mem_wdata;
   rsp_type               rq_push_data;

   assign start  = (state_ff == BK_IDLE) && !job_empty && !clr_busy_ff
                   && (rq_count_ff < RQ_COUNT_W'(RQ_DEPTH));
   assign finish = (state_ff == BK_LOOKUP);
   assign rq_pop = rsp_pop && (rq_count_ff != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (start) state_in = BK_LOOKUP;
         BK_LOOKUP: state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   assign job_in = start ? job_data : job_ff;

   // hysteresis: the previous level picks which side of each margin applies
   always_comb begin
      prev = job_ff.restart ? LEVEL_NEAR : rd_lvl_ff;
      case (prev)
         LEVEL_NEAR: begin
            if (job_ff.cmp.beyond_far_up) level = LEVEL_FAR;
            else if (job_ff.cmp.beyond_near_up) level = LEVEL_MID;
            else level = LEVEL_NEAR;
         end
         LEVEL_MID: begin
            if (job_ff.cmp.within_near_dn) level = LEVEL_NEAR;
            else if (job_ff.cmp.beyond_far_up) level = LEVEL_FAR;
            else level = LEVEL_MID;
         end
         default: begin
            if (job_ff.cmp.within_near_dn) level = LEVEL_NEAR;
            else if (job_ff.cmp.within_far_dn) level = LEVEL_MID;
            else level = LEVEL_FAR;
         end
      endcase
      if ((job_ff.levels_available != '0) && (level >= job_ff.levels_available)) begin
         level = job_ff.levels_available - AVAIL_W'(1);
      end
   end

   // clearing pass after reset, one entry a cycle
   always_comb begin
      clr_in      = clr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_in = clr_ff + SLOT_W'(1);
         if (clr_ff == SLOT_W'(MAX_OBJECTS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   assign mem_we    = clr_busy_ff || finish;
   assign mem_waddr = clr_busy_ff ? clr_ff : job_ff.object_id[SLOT_W-1:0];
   assign mem_wdata = clr_busy_ff ? LEVEL_NEAR : level;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lvl_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (start) begin
         rd_lvl_ff <= lvl_mem_ff[job_data.object_id[SLOT_W-1:0]];
      end
   end

   // result queue
   assign rq_push_data.result_id    = job_ff.object_id;
   assign rq_push_data.detail_level = level;

   always_comb begin
      rq_wr_in    = finish ? rq_wr_ff + RQ_PTR_W'(1) : rq_wr_ff;
      rq_rd_in    = rq_pop ? rq_rd_ff + RQ_PTR_W'(1) : rq_rd_ff;
      rq_count_in = rq_count_ff;
      if (finish && !rq_pop) begin
         rq_count_in = rq_count_ff + RQ_COUNT_W'(1);
      end else if (rq_pop && !finish) begin
         rq_count_in = rq_count_ff - RQ_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rq_ff[rq_wr_ff] <= rq_push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         clr_busy_ff <= clr_busy_in;
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_pop          = start;
   assign rsp_empty        = (rq_count_ff == '0);
   assign rsp_result_id    = rq_ff[rq_rd_ff].result_id;
   assign rsp_detail_level = rq_ff[rq_rd_ff].detail_level;
   assign clear_busy       = clr_busy_ff;

endmodule
`default_nettype wire

### hw/rtl/lod_select_with_hysteresis.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lod_select_with_hysteresis
// Distance level-of-detail selector with per-object hysteresis.
// ---------------------------------------------------------------------------
// Each object pushed in gets one result: its id and a detail level 0..2,
// chosen by exact squared-distance compares against the near and far
// switch distances widened by the margin, clipped to levels_available.
// A four-stage distance pipeline feeds an eight-entry queue; the back end
// then handles one object at a time (level table read, then decide and
// write back) and takes no new object while the result queue is full.
// After reset, full stays high while the level table is cleared, one
// entry at a time; configuration writes are taken during that time.
module lod_select_with_hysteresis (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [lodsel_pkg::ID_W-1:0]         req_object_id,
   input  wire logic [lodsel_pkg::COORD_W-1:0]      req_pos_x,
   input  wire logic [lodsel_pkg::COORD_W-1:0]      req_pos_y,
   input  wire logic [lodsel_pkg::COORD_W-1:0]      req_pos_z,
   input  wire logic [lodsel_pkg::AVAIL_W-1:0]      req_levels_available,
   input  wire logic                                req_restart,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [lodsel_pkg::ID_W-1:0]              rsp_result_id,
   output logic [lodsel_pkg::LEVEL_W-1:0]           rsp_detail_level,
   input  wire logic                                csr_write_enable,
   input  wire logic [lodsel_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lodsel_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lodsel_pkg::*;

   cfg_type               cfg;
   logic [FE_COUNT_W-1:0] in_flight;
   logic                  fe_push;
   job_type               fe_data;
   job_type               cq_data;
   logic                  cq_empty;
   logic                  cq_pop;
   logic [CQ_COUNT_W-1:0] cq_count;
   logic [CQ_COUNT_W-1:0] reserved;
   logic                  clear_busy;
   logic                  accept;

   // reserve a queue slot for every object still in the front pipeline
   assign reserved = cq_count + CQ_COUNT_W'(in_flight);
   assign req_full = clear_busy || (reserved >= CQ_COUNT_W'(CQ_DEPTH));
   assign accept   = req_push && !req_full;

   lodsel_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .wdata        (csr_wdata),
      .cfg          (cfg)
   );

   lodsel_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .object_id        (req_object_id),
      .pos_x            (req_pos_x),
      .pos_y            (req_pos_y),
      .pos_z            (req_pos_z),
      .levels_available (req_levels_available),
      .restart          (req_restart),
      .cfg              (cfg),
      .in_flight        (in_flight),
      .push             (fe_push),
      .push_data        (fe_data)
   );

   lodsel_cq u_cq (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_data),
      .pop       (cq_pop),
      .pop_data  (cq_data),
      .empty     (cq_empty),
      .count     (cq_count)
   );

   lodsel_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_empty        (cq_empty),
      .job_data         (cq_data),
      .job_pop          (cq_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_id    (rsp_result_id),
      .rsp_detail_level (rsp_detail_level),
      .clear_busy       (clear_busy)
   );

endmodule
`default_nettype wire
